[sv/lfpid_pkg.sv]
// Shared types and constants for the line-follow PID differential drive unit.
`default_nettype none
package lfpid_pkg;

	// Width of the shared accumulator datapath
	localparam int ACC_W = 64;

	// Configuration register indexes
	localparam logic [2:0] REG_TARGET     = 3'd0;
	localparam logic [2:0] REG_GAIN_PROP  = 3'd1;
	localparam logic [2:0] REG_GAIN_INTEG = 3'd2;
	localparam logic [2:0] REG_GAIN_DERIV = 3'd3;
	localparam logic [2:0] REG_TURN_BIAS  = 3'd4;
	localparam logic [2:0] REG_BASE_DRIVE = 3'd5;
	localparam logic [2:0] REG_SLOW_TURN  = 3'd6;
	localparam logic [2:0] REG_SLOW_DERIV = 3'd7;

	// Input command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_RESET  = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] reflection;
	} in_t;

	typedef struct packed {
		logic signed [7:0] left_drive;
		logic signed [7:0] right_drive;
	} out_t;

endpackage
`default_nettype wire

[sv/lfpid_alu.sv]
// Shared add/subtract unit used by the multiply, wheel-sum, absolute-value and division steps of the sequencer.
`default_nettype none
module lfpid_alu (
	input  wire logic signed [lfpid_pkg::ACC_W-1:0] a,
	input  wire logic signed [lfpid_pkg::ACC_W-1:0] b,
	input  wire logic                               sub,
	output logic signed [lfpid_pkg::ACC_W-1:0]      y
);
	import lfpid_pkg::*;

	logic [ACC_W-1:0] b_inv;

	// Invert and carry in for subtract
	assign b_inv = sub ? ~b : b;
	assign y = a + $signed(b_inv) + $signed({{(ACC_W-1){1'b0}}, sub});

endmodule
`default_nettype wire

[sv/line_follow_pid_differential_drive_unit.sv]
// Top level of the line-follow PID differential drive unit.
// One item (a reflection sample or a reset command) yields one pair of wheel commands.
// A sample runs five multiplies and, when the wheel values must be scaled down to
// DRIVE_LIMIT, two divisions; a reset command goes straight to the output. These
// run on the single shared 64-bit adder: the 16-bit shift-add multiplies take one
// bit per cycle, the divisions are 8-step restoring ones. in_stall is high while an
// item is in work; the next item is taken while the finished result waits in the
// output register. Configuration writes are always ready and must be made while idle.
`default_nettype none
module line_follow_pid_differential_drive_unit #(
	parameter int MIN_DRIVE_RATIO_Q8 = 77,
	parameter int DRIVE_LIMIT        = 100
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire lfpid_pkg::in_t   in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output lfpid_pkg::out_t       out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [15:0]      cfg_data
);
	import lfpid_pkg::*;

	localparam int QW = 8;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_NEXT  = 4'd2;
	localparam logic [3:0] S_FLOOR = 4'd3;
	localparam logic [3:0] S_LEFT  = 4'd4;
	localparam logic [3:0] S_RIGHT = 4'd5;
	localparam logic [3:0] S_ABSL  = 4'd6;
	localparam logic [3:0] S_ABSR  = 4'd7;
	localparam logic [3:0] S_BIG   = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	// Configuration registers
	logic        [7:0]  target_q;
	logic signed [15:0] gain_prop_q, gain_integ_q, gain_deriv_q, turn_bias_q;
	logic        [6:0]  base_q;
	logic        [15:0] slow_turn_q, slow_deriv_q;

	// Loop state
	logic signed [23:0] error_sum_q;
	logic        [7:0]  last_q;

	// Sequencer and datapath
	logic [3:0]  state_q;
	logic [3:0]  cnt_q;
	logic [2:0]  phase_q;
	logic signed [ACC_W-1:0] acc_q, mcand_q, turn_q, speed_q, left_q, right_q;
	logic signed [ACC_W-1:0] mag_l_q, mag_r_q, big_q, rem_q, dsr_q;
	logic [15:0] mplier_q;
	logic        neg_q;
	logic signed [8:0] deriv_q;
	logic [QW-1:0] quo_q, ql_q, qr_q;
	logic        lneg_q, rneg_q;

	logic signed [ACC_W-1:0] alu_a, alu_b, alu_y;
	logic                    alu_sub;

	logic signed [8:0]  err_c, deriv_c;
	logic signed [24:0] sum_c;
	logic signed [23:0] sum_sat;
	logic signed [ACC_W-1:0] floor_c, lim_c, big_c;
	logic [QW-1:0] quo_next;

	lfpid_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.y   (alu_y)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);

	// Error, derivative and saturated integral of the incoming sample
	assign err_c   = $signed({1'b0, in_data.reflection}) - $signed({1'b0, target_q});
	assign deriv_c = $signed({1'b0, in_data.reflection}) - $signed({1'b0, last_q});
	assign sum_c   = 25'(error_sum_q) + 25'(err_c);
	always_comb begin
		if (sum_c > 25'sd8388607)
			sum_sat = 24'sh7FFFFF;
		else if (sum_c < -25'sd8388608)
			sum_sat = 24'sh800000;
		else
			sum_sat = sum_c[23:0];
	end

	assign floor_c = $signed(ACC_W'({57'd0, base_q} * ACC_W'(MIN_DRIVE_RATIO_Q8)) << 8);
	assign lim_c   = $signed(ACC_W'(DRIVE_LIMIT) << 16);
	assign big_c   = (mag_r_q > mag_l_q) ? mag_r_q : mag_l_q;
	assign quo_next = {quo_q[QW-2:0], ~alu_y[ACC_W-1]};

	// Select operands for the shared adder
	always_comb begin
		alu_a   = acc_q;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_MUL: begin
				alu_b   = mcand_q;
				alu_sub = neg_q;
			end
			S_LEFT: begin
				alu_a   = speed_q;
				alu_b   = turn_q <<< 8;
				alu_sub = 1'b1;
			end
			S_RIGHT: begin
				alu_a = speed_q;
				alu_b = turn_q <<< 8;
			end
			S_ABSL: begin
				alu_a   = '0;
				alu_b   = left_q;
				alu_sub = 1'b1;
			end
			S_ABSR: begin
				alu_a   = '0;
				alu_b   = right_q;
				alu_sub = 1'b1;
			end
			S_DIV: begin
				alu_a   = rem_q;
				alu_b   = dsr_q;
				alu_sub = 1'b1;
			end
			default: begin
				alu_a = acc_q;
			end
		endcase
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= 8'd50;
			gain_prop_q  <= 16'sd256;
			gain_integ_q <= '0;
			gain_deriv_q <= '0;
			turn_bias_q  <= '0;
			base_q       <= 7'd50;
			slow_turn_q  <= '0;
			slow_deriv_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TARGET:     target_q     <= cfg_data[7:0];
				REG_GAIN_PROP:  gain_prop_q  <= cfg_data;
				REG_GAIN_INTEG: gain_integ_q <= cfg_data;
				REG_GAIN_DERIV: gain_deriv_q <= cfg_data;
				REG_TURN_BIAS:  turn_bias_q  <= cfg_data;
				REG_BASE_DRIVE: base_q       <= cfg_data[6:0];
				REG_SLOW_TURN:  slow_turn_q  <= cfg_data;
				REG_SLOW_DERIV: slow_deriv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control: sequencer state, loop state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			error_sum_q <= '0;
			last_q      <= '0;
			out_valid   <= 1'b0;
			cnt_q       <= '0;
			phase_q     <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != S_DONE)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						phase_q <= '0;
						if (in_data.cmd == CMD_RESET) begin
							error_sum_q <= '0;
							last_q      <= '0;
							state_q     <= S_DONE;
						end else begin
							error_sum_q <= sum_sat;
							last_q      <= in_data.reflection;
							state_q     <= S_MUL;
						end
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15)
						state_q <= S_NEXT;
				end
				S_NEXT: begin
					phase_q <= phase_q + 3'd1;
					state_q <= (phase_q == 3'd4) ? S_FLOOR : S_MUL;
				end
				S_FLOOR: state_q <= S_LEFT;
				S_LEFT:  state_q <= S_RIGHT;
				S_RIGHT: state_q <= S_ABSL;
				S_ABSL:  state_q <= S_ABSR;
				S_ABSR:  state_q <= S_BIG;
				S_BIG: begin
					cnt_q   <= '0;
					phase_q <= '0;
					state_q <= (big_c > lim_c) ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (cnt_q == 4'(QW - 1)) begin
						cnt_q <= '0;
						if (phase_q == 3'd0)
							phase_q <= 3'd1;
						else
							state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				deriv_q  <= deriv_c;
				acc_q    <= ACC_W'(turn_bias_q);
				mcand_q  <= ACC_W'(err_c);
				mplier_q <= gain_prop_q[15] ? 16'(-gain_prop_q) : gain_prop_q;
				neg_q    <= gain_prop_q[15];
				ql_q     <= '0;
				qr_q     <= '0;
				lneg_q   <= 1'b0;
				rneg_q   <= 1'b0;
			end
			S_MUL: begin
				if (mplier_q[0])
					acc_q <= alu_y;
				mcand_q  <= mcand_q <<< 1;
				mplier_q <= mplier_q >> 1;
			end
			S_NEXT: begin
				case (phase_q)
					3'd0: begin
						mcand_q  <= ACC_W'(error_sum_q);
						mplier_q <= gain_integ_q[15] ? 16'(-gain_integ_q) : gain_integ_q;
						neg_q    <= ~gain_integ_q[15];
					end
					3'd1: begin
						mcand_q  <= ACC_W'(deriv_q);
						mplier_q <= gain_deriv_q[15] ? 16'(-gain_deriv_q) : gain_deriv_q;
						neg_q    <= gain_deriv_q[15];
					end
					3'd2: begin
						turn_q   <= acc_q;
						acc_q    <= $signed(ACC_W'(base_q) << 16);
						mcand_q  <= acc_q;
						mplier_q <= slow_turn_q;
						neg_q    <= ~acc_q[ACC_W-1];
					end
					3'd3: begin
						mcand_q  <= ACC_W'(deriv_q) <<< 8;
						mplier_q <= slow_deriv_q;
						neg_q    <= ~deriv_q[8];
					end
					default: ;
				endcase
			end
			S_FLOOR: speed_q <= (acc_q < floor_c) ? floor_c : acc_q;
			S_LEFT:  left_q  <= alu_y;
			S_RIGHT: right_q <= alu_y;
			S_ABSL: begin
				mag_l_q <= left_q[ACC_W-1] ? alu_y : left_q;
				lneg_q  <= left_q[ACC_W-1];
			end
			S_ABSR: begin
				mag_r_q <= right_q[ACC_W-1] ? alu_y : right_q;
				rneg_q  <= right_q[ACC_W-1];
			end
			S_BIG: begin
				big_q <= big_c;
				rem_q <= $signed(ACC_W'(mag_l_q * ACC_W'(DRIVE_LIMIT)));
				dsr_q <= big_c <<< (QW - 1);
				ql_q  <= mag_l_q[16 +: QW];
				qr_q  <= mag_r_q[16 +: QW];
			end
			S_DIV: begin
				quo_q <= quo_next;
				if (cnt_q == 4'(QW - 1)) begin
					if (phase_q == 3'd0) begin
						ql_q  <= quo_next;
						rem_q <= $signed(ACC_W'(mag_r_q * ACC_W'(DRIVE_LIMIT)));
						dsr_q <= big_q <<< (QW - 1);
					end else begin
						qr_q <= quo_next;
					end
				end else begin
					// Restoring step: keep the remainder when the trial stays nonnegative
					if (!alu_y[ACC_W-1])
						rem_q <= alu_y;
					dsr_q <= dsr_q >>> 1;
				end
			end
			S_DONE: begin
				if (!out_valid || !out_stall) begin
					out_data.left_drive  <= lneg_q ? -$signed(ql_q) : $signed(ql_q);
					out_data.right_drive <= rneg_q ? -$signed(qr_q) : $signed(qr_q);
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
